/* hw/rtl/dual_rate_history_minmax_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the dual-rate history block
// Shorthand for clocked assertions with an active-low reset disable.
// ---------------------------------------------------------------------------
`ifndef DUAL_RATE_HISTORY_MINMAX_ASSERT_SVH
`define DUAL_RATE_HISTORY_MINMAX_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define DRHM_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define DRHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/drhm_pkg.sv */
// ---------------------------------------------------------------------------
// drhm_pkg
// Types and constants shared by the dual-rate history block and its channels.
// ---------------------------------------------------------------------------
`default_nettype none

package drhm_pkg;

    localparam int TIME_W  = 40;
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 7;
    localparam int COUNT_W = 8;
    localparam int RES_W   = 8;
    localparam int SPACE_W = 32;
    localparam int CFGA_W  = 2;

    localparam logic [RES_W-1:0]   RESOLUTION_RESET = 8'd120;
    localparam logic [SPACE_W-1:0] SHORT_SPACING_RESET = 32'd5000;
    localparam logic [SPACE_W-1:0] LONG_SPACING_RESET  = 32'd30000;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_QUERY  = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [CFGA_W-1:0] {
        REG_RESOLUTION    = 2'd0,
        REG_SHORT_SPACING = 2'd1,
        REG_LONG_SPACING  = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_LOOK,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0]         time_ms;
        logic signed [VALUE_W-1:0] value;
    } point_t;

    typedef struct packed {
        logic [1:0]                op;
        logic [TIME_W-1:0]         sample_time_ms;
        logic signed [VALUE_W-1:0] sample_value;
        logic                      history_select;
        logic [INDEX_W-1:0]        entry_index;
    } req_t;

    typedef struct packed {
        logic                      stored_short;
        logic                      stored_long;
        logic signed [VALUE_W-1:0] found_max;
        logic signed [VALUE_W-1:0] found_min;
        logic                      history_empty;
        logic [COUNT_W-1:0]        entry_count;
        logic [TIME_W-1:0]         entry_time;
        logic signed [VALUE_W-1:0] entry_value;
        logic                      entry_present;
    } rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/drhm_if.sv */
// ---------------------------------------------------------------------------
// drhm channel interfaces
// Valid/ready channels for requests, results and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface drhm_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          op;
    logic [drhm_pkg::TIME_W-1:0]         sample_time_ms;
    logic signed [drhm_pkg::VALUE_W-1:0] sample_value;
    logic                                history_select;
    logic [drhm_pkg::INDEX_W-1:0]        entry_index;

    modport source (output valid, op, sample_time_ms, sample_value, history_select,
                    entry_index, input ready);
    modport sink   (input valid, op, sample_time_ms, sample_value, history_select,
                    entry_index, output ready);
endinterface

interface drhm_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                stored_short;
    logic                                stored_long;
    logic signed [drhm_pkg::VALUE_W-1:0] found_max;
    logic signed [drhm_pkg::VALUE_W-1:0] found_min;
    logic                                history_empty;
    logic [drhm_pkg::COUNT_W-1:0]        entry_count;
    logic [drhm_pkg::TIME_W-1:0]         entry_time;
    logic signed [drhm_pkg::VALUE_W-1:0] entry_value;
    logic                                entry_present;

    modport source (output valid, stored_short, stored_long, found_max, found_min,
                    history_empty, entry_count, entry_time, entry_value, entry_present,
                    input ready);
    modport sink   (input valid, stored_short, stored_long, found_max, found_min,
                    history_empty, entry_count, entry_time, entry_value, entry_present,
                    output ready);
endinterface

interface drhm_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [drhm_pkg::CFGA_W-1:0]   index;
    logic [drhm_pkg::SPACE_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dual_rate_history_minmax.sv */
// ---------------------------------------------------------------------------
// dual_rate_history_minmax
// Two decimated sample histories in block memory, with extreme-value query
// and indexed read.
// ---------------------------------------------------------------------------
// The block keeps a short and a long history of timestamped Q16.16 samples,
// each in its own one-port-write, one-port-read memory of HISTORY_DEPTH
// points with a registered read. Requests are handled one at a time. A
// sample first reads each history's newest point, then compares and writes
// back, then loads the result register. A read reads the indexed entry,
// captures it, then loads the result register. A query walks the selected
// history one memory read per point before loading the result register;
// an empty query skips the walk. The next request is taken in the cycle
// after the result register is loaded. The result sits in an output
// register, so the next request is taken while a result still waits for
// its transfer. Writing the resolution register clears both histories
// through their fill counts; there is no clearing pass. Register writes
// are expected only while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module dual_rate_history_minmax #(
    parameter int HISTORY_DEPTH = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    drhm_req_if.sink   req,
    drhm_rsp_if.source rsp,
    drhm_cfg_if.sink   cfg
);

    localparam int IDXW = $clog2(HISTORY_DEPTH);
    localparam int CNTW = $clog2(HISTORY_DEPTH + 1);
    localparam int SUMW = CNTW + 1;
    localparam int CMPW = (CNTW > drhm_pkg::RES_W) ? CNTW : drhm_pkg::RES_W;
    localparam int TSUMW = drhm_pkg::TIME_W + 1;

    // Slot of the point at a given offset from the oldest one.
    function automatic logic [IDXW-1:0] slot_of(input logic [IDXW-1:0] base,
                                                input logic [CNTW-1:0] off);
        logic [SUMW-1:0] sum;
        sum = SUMW'(base) + SUMW'(off);
        if (sum >= SUMW'(HISTORY_DEPTH))
            sum = sum - SUMW'(HISTORY_DEPTH);
        return sum[IDXW-1:0];
    endfunction

    function automatic logic [IDXW-1:0] slot_inc(input logic [IDXW-1:0] s);
        return (s == IDXW'(HISTORY_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [drhm_pkg::COUNT_W-1:0] count_out(input logic [CNTW-1:0] n);
        logic [CMPW-1:0] wide;
        wide = CMPW'(n);
        return wide[drhm_pkg::COUNT_W-1:0];
    endfunction

    // Point memories, one per history.
    drhm_pkg::point_t s_mem [HISTORY_DEPTH];
    drhm_pkg::point_t l_mem [HISTORY_DEPTH];
    drhm_pkg::point_t s_rdata_reg;
    drhm_pkg::point_t l_rdata_reg;

    drhm_pkg::state_t state_reg;
    drhm_pkg::state_t state_next;

    // Configuration registers.
    logic [drhm_pkg::RES_W-1:0]   resolution_reg;
    logic [drhm_pkg::SPACE_W-1:0] s_spacing_reg;
    logic [drhm_pkg::SPACE_W-1:0] l_spacing_reg;

    // Ring pointers and fill counts of each history.
    logic [IDXW-1:0] s_oldest_reg;
    logic [IDXW-1:0] l_oldest_reg;
    logic [CNTW-1:0] s_held_reg;
    logic [CNTW-1:0] l_held_reg;

    // Request being worked on and the result being built.
    drhm_pkg::req_t req_reg;
    drhm_pkg::rsp_t res_reg;
    drhm_pkg::rsp_t out_reg;
    logic           out_valid_reg;

    // Query walk.
    logic [CNTW-1:0] scan_pos_reg;
    logic [IDXW-1:0] scan_slot_reg;
    logic            scan_valid_reg;
    logic            scan_first_reg;

    logic                 req_xfer;
    logic                 cfg_xfer;
    logic                 out_free;
    logic [CNTW-1:0]      held_in;
    logic [IDXW-1:0]      oldest_in;
    logic [CNTW-1:0]      sel_held;
    logic [IDXW-1:0]      sel_oldest;
    drhm_pkg::point_t     sel_rdata;
    logic [CMPW-1:0]      res_wide;
    logic [CMPW-1:0]      cap_wide;
    logic [CNTW-1:0]      cap;
    logic                 sample_look;
    logic                 s_store;
    logic                 l_store;
    logic [IDXW-1:0]      s_waddr;
    logic [IDXW-1:0]      l_waddr;
    logic [IDXW-1:0]      s_raddr;
    logic [IDXW-1:0]      l_raddr;
    logic [IDXW-1:0]      read_slot;
    logic                 rd_en;
    logic                 scan_issue;
    logic                 read_present;
    drhm_pkg::point_t     new_point;
    drhm_pkg::rsp_t       res_init;

    assign req_xfer = req.valid && req.ready;
    assign cfg_xfer = cfg.valid && cfg.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready = (state_reg == drhm_pkg::ST_IDLE);
    assign cfg.ready = 1'b1;

    assign held_in    = req.history_select ? l_held_reg : s_held_reg;
    assign oldest_in  = req.history_select ? l_oldest_reg : s_oldest_reg;
    assign sel_held   = req_reg.history_select ? l_held_reg : s_held_reg;
    assign sel_oldest = req_reg.history_select ? l_oldest_reg : s_oldest_reg;
    assign sel_rdata  = req_reg.history_select ? l_rdata_reg : s_rdata_reg;

    // Clamp resolution to 1..HISTORY_DEPTH.
    assign res_wide = CMPW'(resolution_reg);
    assign cap_wide = (res_wide == '0) ? CMPW'(1) :
                      (res_wide > CMPW'(HISTORY_DEPTH)) ? CMPW'(HISTORY_DEPTH) : res_wide;
    assign cap = cap_wide[CNTW-1:0];

    // Sample decision: store when empty or spacing has elapsed since the newest point.
    assign sample_look = (state_reg == drhm_pkg::ST_LOOK) &&
                         (req_reg.op == drhm_pkg::OP_SAMPLE);
    assign s_store = (s_held_reg == '0) ||
                     (TSUMW'(req_reg.sample_time_ms) >=
                      TSUMW'(s_rdata_reg.time_ms) + TSUMW'(s_spacing_reg));
    assign l_store = (l_held_reg == '0) ||
                     (TSUMW'(req_reg.sample_time_ms) >=
                      TSUMW'(l_rdata_reg.time_ms) + TSUMW'(l_spacing_reg));
    assign s_waddr = slot_of(s_oldest_reg, s_held_reg);
    assign l_waddr = slot_of(l_oldest_reg, l_held_reg);
    assign new_point.time_ms = req_reg.sample_time_ms;
    assign new_point.value   = req_reg.sample_value;

    assign read_present = CMPW'(req_reg.entry_index) < CMPW'(sel_held);
    assign read_slot    = slot_of(sel_oldest, CNTW'(req_reg.entry_index));
    assign scan_issue   = scan_pos_reg < sel_held;

    // Starting result for a new request: queries and reads report the fill
    // state of the selected history, everything else starts at zero.
    always_comb
    begin
        res_init = '0;
        if ((req.op == drhm_pkg::OP_QUERY) || (req.op == drhm_pkg::OP_READ))
        begin
            res_init.history_empty = (held_in == '0);
            res_init.entry_count   = count_out(held_in);
        end
    end

    // Read address: newest point for a sample, indexed entry for a read,
    // walk pointer for a query.
    always_comb
    begin
        s_raddr = scan_slot_reg;
        l_raddr = scan_slot_reg;
        rd_en   = 1'b0;
        if (state_reg == drhm_pkg::ST_ISSUE)
        begin
            rd_en = 1'b1;
            if (req_reg.op == drhm_pkg::OP_SAMPLE)
            begin
                s_raddr = slot_of(s_oldest_reg, s_held_reg - 1'b1);
                l_raddr = slot_of(l_oldest_reg, l_held_reg - 1'b1);
            end
            else
            begin
                s_raddr = read_slot;
                l_raddr = read_slot;
            end
        end
        else if (state_reg == drhm_pkg::ST_SCAN)
        begin
            rd_en = scan_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_look && s_store)
            s_mem[s_waddr] <= new_point;
        if (sample_look && l_store)
            l_mem[l_waddr] <= new_point;
        if (rd_en)
        begin
            s_rdata_reg <= s_mem[s_raddr];
            l_rdata_reg <= l_mem[l_raddr];
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= drhm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            drhm_pkg::ST_IDLE:
            begin
                if (req_xfer)
                begin
                    unique case (req.op) inside
                        drhm_pkg::OP_SAMPLE,
                        drhm_pkg::OP_READ:  state_next = drhm_pkg::ST_ISSUE;
                        drhm_pkg::OP_QUERY: state_next = (held_in == '0) ?
                                                         drhm_pkg::ST_FINISH :
                                                         drhm_pkg::ST_SCAN;
                        default:            state_next = drhm_pkg::ST_FINISH;
                    endcase
                end
            end
            drhm_pkg::ST_ISSUE:  state_next = drhm_pkg::ST_LOOK;
            drhm_pkg::ST_LOOK:   state_next = drhm_pkg::ST_FINISH;
            drhm_pkg::ST_SCAN:
            begin
                if (!scan_issue && !scan_valid_reg)
                    state_next = drhm_pkg::ST_FINISH;
            end
            drhm_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = drhm_pkg::ST_IDLE;
            end
            default:             state_next = drhm_pkg::ST_IDLE;
        endcase
    end

    // Control state: registers, ring pointers, walk control, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg <= drhm_pkg::RESOLUTION_RESET;
            s_spacing_reg  <= drhm_pkg::SHORT_SPACING_RESET;
            l_spacing_reg  <= drhm_pkg::LONG_SPACING_RESET;
            s_oldest_reg   <= '0;
            l_oldest_reg   <= '0;
            s_held_reg     <= '0;
            l_held_reg     <= '0;
            out_valid_reg  <= 1'b0;
            scan_pos_reg   <= '0;
            scan_valid_reg <= 1'b0;
            scan_first_reg <= 1'b0;
        end
        else
        begin
            // Advance each ring that takes the sample; drop the oldest when full.
            if (sample_look && s_store)
            begin
                if (s_held_reg == cap)
                    s_oldest_reg <= slot_inc(s_oldest_reg);
                else
                    s_held_reg <= s_held_reg + 1'b1;
            end
            if (sample_look && l_store)
            begin
                if (l_held_reg == cap)
                    l_oldest_reg <= slot_inc(l_oldest_reg);
                else
                    l_held_reg <= l_held_reg + 1'b1;
            end

            if (req_xfer)
            begin
                scan_pos_reg   <= '0;
                scan_valid_reg <= 1'b0;
                scan_first_reg <= 1'b1;
            end
            else if (state_reg == drhm_pkg::ST_SCAN)
            begin
                scan_valid_reg <= scan_issue;
                if (scan_issue)
                    scan_pos_reg <= scan_pos_reg + 1'b1;
                if (scan_valid_reg)
                    scan_first_reg <= 1'b0;
            end

            if ((state_reg == drhm_pkg::ST_FINISH) && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            // A resolution write empties both histories.
            if (cfg_xfer)
            begin
                unique case (cfg.index)
                    drhm_pkg::REG_RESOLUTION:
                    begin
                        resolution_reg <= cfg.data[drhm_pkg::RES_W-1:0];
                        s_oldest_reg   <= '0;
                        l_oldest_reg   <= '0;
                        s_held_reg     <= '0;
                        l_held_reg     <= '0;
                    end
                    drhm_pkg::REG_SHORT_SPACING: s_spacing_reg <= cfg.data;
                    drhm_pkg::REG_LONG_SPACING:  l_spacing_reg <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload: request capture, result build-up, output register.
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            req_reg.op             <= req.op;
            req_reg.sample_time_ms <= req.sample_time_ms;
            req_reg.sample_value   <= req.sample_value;
            req_reg.history_select <= req.history_select;
            req_reg.entry_index    <= req.entry_index;
            scan_slot_reg          <= oldest_in;
            res_reg                <= res_init;
        end
        else if (state_reg == drhm_pkg::ST_SCAN)
        begin
            if (scan_issue)
                scan_slot_reg <= slot_inc(scan_slot_reg);
            if (scan_valid_reg)
            begin
                if (scan_first_reg)
                begin
                    res_reg.found_max <= sel_rdata.value;
                    res_reg.found_min <= sel_rdata.value;
                end
                else
                begin
                    if ($signed(sel_rdata.value) > $signed(res_reg.found_max))
                        res_reg.found_max <= sel_rdata.value;
                    if ($signed(sel_rdata.value) < $signed(res_reg.found_min))
                        res_reg.found_min <= sel_rdata.value;
                end
            end
        end
        else if (state_reg == drhm_pkg::ST_LOOK)
        begin
            if (req_reg.op == drhm_pkg::OP_SAMPLE)
            begin
                res_reg.stored_short <= s_store;
                res_reg.stored_long  <= l_store;
            end
            else if (read_present)
            begin
                res_reg.entry_time    <= sel_rdata.time_ms;
                res_reg.entry_value   <= sel_rdata.value;
                res_reg.entry_present <= 1'b1;
            end
        end

        if ((state_reg == drhm_pkg::ST_FINISH) && out_free)
            out_reg <= res_reg;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.stored_short  = out_reg.stored_short;
    assign rsp.stored_long   = out_reg.stored_long;
    assign rsp.found_max     = out_reg.found_max;
    assign rsp.found_min     = out_reg.found_min;
    assign rsp.history_empty = out_reg.history_empty;
    assign rsp.entry_count   = out_reg.entry_count;
    assign rsp.entry_time    = out_reg.entry_time;
    assign rsp.entry_value   = out_reg.entry_value;
    assign rsp.entry_present = out_reg.entry_present;

`include "dual_rate_history_minmax_assert.svh"

    // Fill counts never pass the clamped resolution.
    `DRHM_ASSERT_ALWAYS(a_held_within_cap, clk, rst_n, (s_held_reg <= cap) && (l_held_reg <= cap), "history holds more points than its capacity")

    // The walk never runs past the held points.
    `DRHM_ASSERT_ALWAYS(a_scan_in_range, clk, rst_n, (state_reg != drhm_pkg::ST_SCAN) || (scan_pos_reg <= sel_held), "query walk ran past held points")

    // A finished result lands in the output register and the sequencer frees up.
    `DRHM_ASSERT_NEXT(a_result_loaded, clk, rst_n, (state_reg == drhm_pkg::ST_FINISH) && out_free, out_valid_reg && (state_reg == drhm_pkg::ST_IDLE), "finished result not loaded")

endmodule

`default_nettype wire

/* sim/dual_rate_history_minmax_tb.sv */
// ---------------------------------------------------------------------------
// dual_rate_history_minmax_tb
// Self-checking bench for the dual-rate history block. Requests go in through
// a queue-fed driver, and every result is compared with a cycle-free model of
// both histories kept here. Register settings change between phases, and
// both sides of the request path idle and stall at random.
// ---------------------------------------------------------------------------

module dual_rate_history_minmax_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = 128;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLDOFF_CYCLES = 400;

    // Codes that the package leaves unnamed: the spare op and the spare
    // register index. The block must ignore both.
    localparam logic [1:0]                  OP_UNUSED  = 2'd3;
    localparam logic [drhm_pkg::CFGA_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [drhm_pkg::TIME_W-1:0] TIME_MAX   = '1;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    drhm_req_if req_ch ();
    drhm_rsp_if rsp_ch ();
    drhm_cfg_if cfg_ch ();

    dual_rate_history_minmax #(
        .HISTORY_DEPTH (DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // History model: register copies and both point stores
    // -----------------------------------------------------------------------
    logic [drhm_pkg::RES_W-1:0]          res_setting;
    logic [drhm_pkg::SPACE_W-1:0]        short_gap_ms;
    logic [drhm_pkg::SPACE_W-1:0]        long_gap_ms;
    logic [drhm_pkg::TIME_W-1:0]         hist_time  [2][DEPTH];
    logic signed [drhm_pkg::VALUE_W-1:0] hist_value [2][DEPTH];
    int unsigned                         hist_head  [2];
    int unsigned                         hist_held  [2];
    int unsigned                         deepest_held;

    // Stimulus and expectation stores
    drhm_pkg::req_t queued_requests[$];
    drhm_pkg::rsp_t awaited_results[$];
    drhm_pkg::req_t cur_req;

    // Bookkeeping
    int unsigned requests_queued;
    int unsigned requests_sent;
    int unsigned results_seen;
    int unsigned failures;
    int unsigned quiet_cycles;
    int unsigned holdoff_left;
    bit          holdoff_done;
    int unsigned sample_count;
    int unsigned query_count;
    int unsigned read_count;
    int unsigned unused_op_count;
    int unsigned appended_short;
    int unsigned appended_long;
    int unsigned register_writes;

    // Effective capacity: zero acts as one, anything past the store depth
    // acts as the depth.
    function automatic int unsigned points_allowed();
        if (res_setting == 0)
        begin
            return 1;
        end
        if (res_setting > DEPTH)
        begin
            return DEPTH;
        end
        return res_setting;
    endfunction

    function automatic void clear_histories();
        for (int h = 0; h < 2; h++)
        begin
            hist_head[h] = 0;
            hist_held[h] = 0;
        end
    endfunction

    function automatic void reset_model();
        res_setting  = drhm_pkg::RESOLUTION_RESET;
        short_gap_ms = drhm_pkg::SHORT_SPACING_RESET;
        long_gap_ms  = drhm_pkg::LONG_SPACING_RESET;
        deepest_held = 0;
        clear_histories();
    endfunction

    function automatic void apply_register(logic [drhm_pkg::CFGA_W-1:0] idx,
                                           logic [drhm_pkg::SPACE_W-1:0] data);
        case (idx)
            drhm_pkg::REG_RESOLUTION:
            begin
                res_setting = data[drhm_pkg::RES_W-1:0];
                clear_histories();
            end
            drhm_pkg::REG_SHORT_SPACING: short_gap_ms = data;
            drhm_pkg::REG_LONG_SPACING:  long_gap_ms  = data;
            default: ;
        endcase
    endfunction

    // Append a point if the history is empty or its newest point is at least
    // one spacing older; a full history gives up its oldest point first.
    function automatic bit append_point(int h, logic [drhm_pkg::TIME_W-1:0] t_ms,
                                        logic signed [drhm_pkg::VALUE_W-1:0] v,
                                        logic [drhm_pkg::SPACE_W-1:0] gap);
        int unsigned     limit;
        int unsigned     slot;
        longint unsigned newest;
        longint unsigned arrival;
        longint unsigned gap_wide;
        limit = points_allowed();
        if (hist_held[h] != 0)
        begin
            slot     = (hist_head[h] + hist_held[h] - 1) % DEPTH;
            newest   = hist_time[h][slot];
            arrival  = t_ms;
            gap_wide = gap;
            if (arrival < newest + gap_wide)
            begin
                return 1'b0;
            end
        end
        while (hist_held[h] >= limit)
        begin
            hist_head[h] = (hist_head[h] + 1) % DEPTH;
            hist_held[h] = hist_held[h] - 1;
        end
        slot = (hist_head[h] + hist_held[h]) % DEPTH;
        hist_time[h][slot]  = t_ms;
        hist_value[h][slot] = v;
        hist_held[h] = hist_held[h] + 1;
        if (hist_held[h] > deepest_held)
        begin
            deepest_held = hist_held[h];
        end
        return 1'b1;
    endfunction

    function automatic drhm_pkg::rsp_t expected_result(drhm_pkg::req_t r);
        drhm_pkg::rsp_t                      o;
        int                                  h;
        int unsigned                         slot;
        logic signed [drhm_pkg::VALUE_W-1:0] hi;
        logic signed [drhm_pkg::VALUE_W-1:0] lo;
        logic signed [drhm_pkg::VALUE_W-1:0] v;
        o = '0;
        h = r.history_select ? 1 : 0;
        case (r.op)
            drhm_pkg::OP_SAMPLE:
            begin
                o.stored_short = append_point(0, r.sample_time_ms, r.sample_value,
                                              short_gap_ms);
                o.stored_long  = append_point(1, r.sample_time_ms, r.sample_value,
                                              long_gap_ms);
            end
            drhm_pkg::OP_QUERY:
            begin
                o.entry_count = drhm_pkg::COUNT_W'(hist_held[h]);
                if (hist_held[h] == 0)
                begin
                    o.history_empty = 1'b1;
                end
                else
                begin
                    hi = hist_value[h][hist_head[h]];
                    lo = hi;
                    for (int unsigned p = 1; p < hist_held[h]; p++)
                    begin
                        v = hist_value[h][(hist_head[h] + p) % DEPTH];
                        if (v > hi)
                        begin
                            hi = v;
                        end
                        if (v < lo)
                        begin
                            lo = v;
                        end
                    end
                    o.found_max = hi;
                    o.found_min = lo;
                end
            end
            drhm_pkg::OP_READ:
            begin
                o.history_empty = (hist_held[h] == 0);
                o.entry_count   = drhm_pkg::COUNT_W'(hist_held[h]);
                if (r.entry_index < hist_held[h])
                begin
                    slot            = (hist_head[h] + r.entry_index) % DEPTH;
                    o.entry_time    = hist_time[h][slot];
                    o.entry_value   = hist_value[h][slot];
                    o.entry_present = 1'b1;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic bit results_match(drhm_pkg::rsp_t a, drhm_pkg::rsp_t b);
        return (a.stored_short  === b.stored_short)  &&
               (a.stored_long   === b.stored_long)   &&
               (a.found_max     === b.found_max)     &&
               (a.found_min     === b.found_min)     &&
               (a.history_empty === b.history_empty) &&
               (a.entry_count   === b.entry_count)   &&
               (a.entry_time    === b.entry_time)    &&
               (a.entry_value   === b.entry_value)   &&
               (a.entry_present === b.entry_present);
    endfunction

    task automatic note_failure(string what, drhm_pkg::rsp_t want, drhm_pkg::rsp_t got);
        failures++;
        if (failures <= REPORT_LIMIT)
        begin
            $display("[%0t] %s", $time, what);
            $display("  expected st=%b%b max=%h min=%h empty=%b cnt=%0d t=%h v=%h pres=%b",
                     want.stored_short, want.stored_long, want.found_max, want.found_min,
                     want.history_empty, want.entry_count, want.entry_time,
                     want.entry_value, want.entry_present);
            $display("  actual   st=%b%b max=%h min=%h empty=%b cnt=%0d t=%h v=%h pres=%b",
                     got.stored_short, got.stored_long, got.found_max, got.found_min,
                     got.history_empty, got.entry_count, got.entry_time,
                     got.entry_value, got.entry_present);
        end
    endtask

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------
    function automatic longint unsigned draw_upto(longint unsigned hi);
        longint unsigned r;
        r = {$urandom, $urandom};
        if (hi == '1)
        begin
            return r;
        end
        return r % (hi + 1);
    endfunction

    // Lean on the extremes of the signed range now and then.
    function automatic logic signed [drhm_pkg::VALUE_W-1:0] draw_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic drhm_pkg::req_t build_req(logic [1:0] op,
                                                 logic [drhm_pkg::TIME_W-1:0] t_ms,
                                                 logic signed [drhm_pkg::VALUE_W-1:0] v,
                                                 logic sel,
                                                 logic [drhm_pkg::INDEX_W-1:0] idx);
        drhm_pkg::req_t r;
        r.op             = op;
        r.sample_time_ms = t_ms;
        r.sample_value   = v;
        r.history_select = sel;
        r.entry_index    = idx;
        return r;
    endfunction

    function automatic void queue_request(drhm_pkg::req_t r);
        queued_requests.push_back(r);
        requests_queued++;
    endfunction

    // Mostly a well-formed sensor stream: timestamps advance by steps sized
    // around the spacings so that both histories fill and roll over, mixed
    // with queries, reads, late samples and the spare op.
    task automatic queue_random_items(int count, longint unsigned base);
        longint unsigned clock_ms;
        longint unsigned step;
        longint unsigned gs;
        longint unsigned gl;
        longint unsigned t_cap;
        longint unsigned back;
        logic [drhm_pkg::TIME_W-1:0] t_ms;
        bit          late;
        int          k;
        clock_ms = base;
        gs       = short_gap_ms;
        gl       = long_gap_ms;
        t_cap    = TIME_MAX;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 55)
            begin
                late = 1'b0;
                step = 0;
                case ($urandom_range(0, 19))
                    0:       step = 0;
                    1:       late = 1'b1;
                    12, 13, 14, 15: step = draw_upto(gs);
                    16, 17, 18:     step = gl * 3 / 4 + draw_upto(gl + gl / 4 + 1);
                    19:      step = draw_upto(64'hFFFF_FFFF);
                    default: step = gs * 3 / 4 + draw_upto(gs + gs / 4 + 1);
                endcase
                if (late)
                begin
                    back = draw_upto((clock_ms < gs + 1) ? clock_ms : gs + 1);
                    t_ms = drhm_pkg::TIME_W'(clock_ms - back);
                end
                else
                begin
                    clock_ms = clock_ms + step;
                    if (clock_ms > t_cap)
                    begin
                        clock_ms = t_cap;
                    end
                    t_ms = drhm_pkg::TIME_W'(clock_ms);
                end
                queue_request(build_req(drhm_pkg::OP_SAMPLE, t_ms, draw_value(),
                                        1'($urandom_range(0, 1)),
                                        drhm_pkg::INDEX_W'($urandom_range(0, 127))));
            end
            else if (k < 73)
            begin
                queue_request(build_req(drhm_pkg::OP_QUERY,
                                        drhm_pkg::TIME_W'(draw_upto(t_cap)), $urandom,
                                        1'($urandom_range(0, 1)),
                                        drhm_pkg::INDEX_W'($urandom_range(0, 127))));
            end
            else if (k < 93)
            begin
                queue_request(build_req(drhm_pkg::OP_READ,
                                        drhm_pkg::TIME_W'(draw_upto(t_cap)), $urandom,
                                        1'($urandom_range(0, 1)),
                                        drhm_pkg::INDEX_W'($urandom_range(0, 1) ?
                                            $urandom_range(0, points_allowed() - 1) :
                                            $urandom_range(0, 127))));
            end
            else
            begin
                queue_request(build_req(OP_UNUSED,
                                        drhm_pkg::TIME_W'(draw_upto(t_cap)), $urandom,
                                        1'($urandom_range(0, 1)),
                                        drhm_pkg::INDEX_W'($urandom_range(0, 127))));
            end
        end
    endtask

    // Hold until every queued request has come back as a result.
    task automatic wait_for_drain();
        while (results_seen != requests_queued)
        begin
            @(posedge clk);
        end
    endtask

    // One register transfer; the model takes the new value at the same edge.
    task automatic write_register(logic [drhm_pkg::CFGA_W-1:0] idx,
                                  logic [drhm_pkg::SPACE_W-1:0] data);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        apply_register(idx, data);
        register_writes++;
    endtask

    // -----------------------------------------------------------------------
    // Request driver: pop the next item once the current one has transferred
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin : request_driver
        drhm_pkg::req_t nxt;
        bit             no_gaps;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            // Predict at the transfer edge, in transfer order.
            if (req_ch.valid && req_ch.ready)
            begin
                awaited_results.push_back(expected_result(cur_req));
                requests_sent++;
                case (cur_req.op)
                    drhm_pkg::OP_SAMPLE: sample_count++;
                    drhm_pkg::OP_QUERY:  query_count++;
                    drhm_pkg::OP_READ:   read_count++;
                    default:             unused_op_count++;
                endcase
            end
            // Keep a gap-free stretch in the middle of the long phase.
            no_gaps = (requests_sent >= 420) && (requests_sent < 520);
            if (!req_ch.valid || req_ch.ready)
            begin
                if (queued_requests.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 25))
                begin
                    nxt     = queued_requests.pop_front();
                    cur_req = nxt;
                    req_ch.valid          <= 1'b1;
                    req_ch.op             <= nxt.op;
                    req_ch.sample_time_ms <= nxt.sample_time_ms;
                    req_ch.sample_value   <= nxt.sample_value;
                    req_ch.history_select <= nxt.history_select;
                    req_ch.entry_index    <= nxt.entry_index;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result monitor: check each transfer against the oldest expectation and
    // drive ready, including one long hold-off while requests keep coming
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin : result_monitor
        drhm_pkg::rsp_t got;
        drhm_pkg::rsp_t want;
        bit             no_stalls;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.stored_short  = rsp_ch.stored_short;
                got.stored_long   = rsp_ch.stored_long;
                got.found_max     = rsp_ch.found_max;
                got.found_min     = rsp_ch.found_min;
                got.history_empty = rsp_ch.history_empty;
                got.entry_count   = rsp_ch.entry_count;
                got.entry_time    = rsp_ch.entry_time;
                got.entry_value   = rsp_ch.entry_value;
                got.entry_present = rsp_ch.entry_present;
                results_seen++;
                if (awaited_results.size() == 0)
                begin
                    note_failure("result transfer with nothing awaited", '0, got);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (want.stored_short)
                    begin
                        appended_short++;
                    end
                    if (want.stored_long)
                    begin
                        appended_long++;
                    end
                    if (!results_match(want, got))
                    begin
                        note_failure("result mismatch", want, got);
                    end
                end
            end
            no_stalls = (results_seen >= 420) && (results_seen < 520);
            if (holdoff_left != 0)
            begin
                holdoff_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!holdoff_done && results_seen >= 300 && queued_requests.size() >= 30)
            begin
                // Back-pressure long enough for the block to stall its input.
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= no_stalls || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: any transfer on any channel counts as progress
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no transfer for %0d cycles", $time, quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sequencer: reset, directed items, then register phases of random items
    // -----------------------------------------------------------------------
    initial
    begin : sequencer
        logic [drhm_pkg::SPACE_W-1:0] word;
        longint unsigned              base;
        int                           count;

        // Every input known from time zero.
        req_ch.valid          = 1'b0;
        req_ch.op             = drhm_pkg::OP_SAMPLE;
        req_ch.sample_time_ms = '0;
        req_ch.sample_value   = '0;
        req_ch.history_select = 1'b0;
        req_ch.entry_index    = '0;
        rsp_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = drhm_pkg::REG_RESOLUTION;
        cfg_ch.data           = '0;
        reset_model();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset settings: empty query and read, the
        // spare op, samples just short of and exactly on the short spacing and
        // exactly on the long spacing, a late sample, reads inside and past the held points, the largest time.
        queue_request(build_req(drhm_pkg::OP_QUERY,  '0, '0, 1'b0, '0));
        queue_request(build_req(drhm_pkg::OP_READ,   '0, '0, 1'b1, '0));
        queue_request(build_req(OP_UNUSED, TIME_MAX, 32'h7FFF_FFFF, 1'b1, 7'd127));
        queue_request(build_req(drhm_pkg::OP_SAMPLE, 40'd0,     32'h7FFF_FFFF, 1'b0, '0));
        queue_request(build_req(drhm_pkg::OP_SAMPLE, 40'd4999,  32'h8000_0000, 1'b0, '0));
        queue_request(build_req(drhm_pkg::OP_SAMPLE, 40'd5000,  32'hFFFF_FFFF, 1'b0, '0));
        queue_request(build_req(drhm_pkg::OP_SAMPLE, 40'd30000, 32'h0000_0000, 1'b0, '0));
        queue_request(build_req(drhm_pkg::OP_SAMPLE, 40'd100,   32'h0000_007B, 1'b1, '0));
        queue_request(build_req(drhm_pkg::OP_QUERY,  '0, '0, 1'b0, '0));
        queue_request(build_req(drhm_pkg::OP_QUERY,  '0, '0, 1'b1, '0));
        queue_request(build_req(drhm_pkg::OP_READ,   '0, '0, 1'b0, 7'd0));
        queue_request(build_req(drhm_pkg::OP_READ,   '0, '0, 1'b0, 7'd2));
        queue_request(build_req(drhm_pkg::OP_READ,   '0, '0, 1'b0, 7'd3));
        queue_request(build_req(drhm_pkg::OP_READ,   '0, '0, 1'b1, 7'd1));
        queue_request(build_req(drhm_pkg::OP_READ,   '0, '0, 1'b1, 7'd127));
        queue_request(build_req(drhm_pkg::OP_SAMPLE, TIME_MAX, 32'h0000_0001, 1'b1, 7'd127));
        queue_request(build_req(drhm_pkg::OP_READ,   '0, '0, 1'b0, 7'd3));
        queue_request(build_req(drhm_pkg::OP_QUERY,  '0, '0, 1'b0, '0));
        queue_request(build_req(drhm_pkg::OP_QUERY,  '0, '0, 1'b1, '0));
        wait_for_drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            // Block is idle here; let it settle before touching registers.
            repeat (SETTLE_CYCLES) @(posedge clk);
            base = draw_upto(40'hF_FFFF);
            case (phase)
                0:
                begin
                    // Single-point histories; every sample not older than the newest point is stored.
                    write_register(drhm_pkg::REG_RESOLUTION, 32'd1);
                    write_register(drhm_pkg::REG_SHORT_SPACING, 32'd0);
                    write_register(drhm_pkg::REG_LONG_SPACING, 32'd0);
                    count = 60;
                    base  = 0;
                end
                1:
                begin
                    write_register(drhm_pkg::REG_RESOLUTION, 32'd0);
                    write_register(drhm_pkg::REG_SHORT_SPACING, 32'd1);
                    write_register(drhm_pkg::REG_LONG_SPACING, 32'd2);
                    count = 60;
                end
                2:
                begin
                    write_register(drhm_pkg::REG_RESOLUTION, 32'd2);
                    write_register(drhm_pkg::REG_SHORT_SPACING, 32'd3);
                    write_register(drhm_pkg::REG_LONG_SPACING, 32'd10);
                    count = 60;
                end
                3:
                begin
                    // Oversized resolution; the spare index must change nothing.
                    write_register(drhm_pkg::REG_RESOLUTION, 32'd255);
                    write_register(drhm_pkg::REG_SHORT_SPACING, 32'd7);
                    write_register(drhm_pkg::REG_LONG_SPACING, 32'd40);
                    write_register(REG_UNUSED, 32'd1);
                    count = 340;
                end
                4:
                begin
                    write_register(drhm_pkg::REG_RESOLUTION, 32'd128);
                    write_register(drhm_pkg::REG_SHORT_SPACING, 32'hFFFF_FFFF);
                    write_register(drhm_pkg::REG_LONG_SPACING, 32'd5);
                    count = 80;
                    base  = 40'hFC_0000_0000;
                end
                5:
                begin
                    write_register(drhm_pkg::REG_RESOLUTION,
                                   32'(drhm_pkg::RESOLUTION_RESET));
                    write_register(drhm_pkg::REG_SHORT_SPACING,
                                   drhm_pkg::SHORT_SPACING_RESET);
                    write_register(drhm_pkg::REG_LONG_SPACING,
                                   drhm_pkg::LONG_SPACING_RESET);
                    count = 100;
                    base  = draw_upto(TIME_MAX);
                end
                6:
                begin
                    write_register(drhm_pkg::REG_RESOLUTION, $urandom_range(3, 130));
                    write_register(drhm_pkg::REG_SHORT_SPACING, $urandom_range(0, 50));
                    write_register(drhm_pkg::REG_LONG_SPACING, $urandom_range(0, 400));
                    count = 120;
                end
                default:
                begin
                    // Junk above the resolution byte must be dropped.
                    word       = $urandom;
                    word[7:0]  = 8'd64;
                    write_register(drhm_pkg::REG_RESOLUTION, word);
                    write_register(drhm_pkg::REG_SHORT_SPACING, $urandom);
                    write_register(drhm_pkg::REG_LONG_SPACING, $urandom);
                    count = 60;
                    base  = draw_upto(TIME_MAX);
                end
            endcase
            queue_random_items(count, base);
            wait_for_drain();
        end

        // Let a stray late result show up before closing out.
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (awaited_results.size() != 0)
        begin
            note_failure("expected result never arrived", awaited_results.pop_front(), '0);
        end

        $display("Covered %0d samples (%0d short, %0d long appends), %0d queries, %0d reads,",
                 sample_count, appended_short, appended_long, query_count, read_count);
        $display("%0d spare ops, %0d register writes, deepest history %0d points, %0d failures",
                 unused_op_count, register_writes, deepest_held, failures);
        if (failures == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* dual_rate_history_minmax.f */
+incdir+hw/rtl
hw/rtl/drhm_pkg.sv
hw/rtl/drhm_if.sv
hw/rtl/dual_rate_history_minmax.sv
sim/dual_rate_history_minmax_tb.sv
